### hw/rtl/wmrq_pkg.sv
// ----------------------------------------------------------------------------
// wmrq_pkg
// Shared constants, types and helpers of the wavelet matrix range query block.
// ----------------------------------------------------------------------------
package wmrq_pkg;

   localparam int VALUE_BITS  = 16;
   localparam int MAX_LENGTH  = 1024;
   localparam int LEN_W       = $clog2(MAX_LENGTH + 1);
   localparam int POS_W       = $clog2(MAX_LENGTH);
   localparam int LVL_W       = $clog2(VALUE_BITS);
   localparam int WORD_BITS   = 32;
   localparam int WORD_SH     = 5;
   localparam int WORDS       = MAX_LENGTH / WORD_BITS + 1;
   localparam int WORD_IDX_W  = $clog2(WORDS);
   localparam int ROW_W       = LVL_W + WORD_IDX_W;
   localparam int ROWS        = VALUE_BITS * (1 << WORD_IDX_W);
   localparam int CNT_W       = 6;

   typedef enum logic [3:0] {
      MODE_LOAD   = 4'd0,
      MODE_BUILD  = 4'd1,
      MODE_ACCESS = 4'd2,
      MODE_RANK   = 4'd3,
      MODE_SELECT = 4'd4,
      MODE_KLARGE = 4'd5,
      MODE_KSMALL = 4'd6,
      MODE_RCOUNT = 4'd7,
      MODE_LESS   = 4'd8,
      MODE_LESSEQ = 4'd9,
      MODE_SUCC   = 4'd10,
      MODE_PRED   = 4'd11
   } mode_type;

   // one rank lookup: bit row word and block prefix
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [LEN_W-1:0]     prefix;
   } rank_row_type;

   function automatic logic [CNT_W-1:0] popcount32(input logic [WORD_BITS-1:0] w);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < WORD_BITS; i++) c = c + CNT_W'(w[i]);
      return c;
   endfunction

   function automatic logic [ROW_W-1:0] row_addr(input logic [LVL_W-1:0] d,
                                                  input logic [LEN_W-1:0] pos);
      return {d, pos[WORD_SH +: WORD_IDX_W]};
   endfunction

endpackage

### hw/rtl/wmrq_ram.sv
// ----------------------------------------------------------------------------
// wmrq_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hw/rtl/wmrq_rank_unit.sv
// ----------------------------------------------------------------------------
// wmrq_rank_unit
// Shared rank unit: masks a bit row word and adds its popcount to the prefix.
// ----------------------------------------------------------------------------
module wmrq_rank_unit import wmrq_pkg::*; (
   input  logic                 clock,
   input  rank_row_type         row,
   input  logic [WORD_SH-1:0]   offset,
   output logic [LEN_W-1:0]     rank_ff,
   output logic                 bit_ff
);

   logic [WORD_BITS-1:0] mask;
   logic [LEN_W-1:0]     rank_in;

   always_comb begin
      mask    = (WORD_BITS'(1) << offset) - WORD_BITS'(1);
      rank_in = row.prefix + LEN_W'(popcount32(row.word & mask));
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      bit_ff  <= row.word[offset];
   end

endmodule

### hw/rtl/wavelet_matrix_range_query.sv
// ----------------------------------------------------------------------------
// wavelet_matrix_range_query
// Wavelet matrix over loaded values with range queries, one rank unit shared.
// ----------------------------------------------------------------------------
// Load: written directly in idle. Build: copy, then per level a scan, flush, ones copy and prefix pass, 16 levels.
// Level walk: per level the states ST_W_ADDR_L, ST_W_ADDR_R, ST_W_RANK_L and ST_W_STEP.
// Queries take one or two walks (plus walks per select search step, about 11).
// One request at a time; req_tready is low while one is in progress.
// Reset clears lengths and zero counts; stores are undefined until written.
module wavelet_matrix_range_query import wmrq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] mode, [19:4] value, [36:20] upper_value, [47:37] left,
   // [58:48] right, [69:59] ordinal, [71:70] zero
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] answer, [16] found, [17] build_done, [23:18] zero
   output logic [23:0] rsp_tdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH,
      ST_BCOPY_RD, ST_BCOPY_WR,
      ST_BLVL, ST_BSCAN_RD, ST_BSCAN_WR, ST_BFLUSH, ST_BONES_RD, ST_BONES_WR,
      ST_BPFX_RD, ST_BPFX_WR,
      ST_W_ADDR_L, ST_W_ADDR_R, ST_W_RANK_L, ST_W_STEP,
      ST_Q_NEXT, ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      PH_ACCESS, PH_RANK, PH_SEL_TOT, PH_SEL_L, PH_SEL_MID, PH_KTH,
      PH_RC_HI, PH_RC_LO, PH_CNT, PH_SP_CNT, PH_SP_KTH
   } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   mode_type             mode_ff, mode_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [16:0]          uv_ff, uv_in;
   logic [LEN_W-1:0]     lq_ff, lq_in, rq_ff, rq_in, kq_ff, kq_in;
   logic [LEN_W-1:0]     stored_ff, stored_in, built_ff, built_in;
   logic [LEN_W-1:0]     zc_ff [VALUE_BITS];
   logic                 zc_we;
   logic [LEN_W-1:0]     zc_wd;
   // walk registers
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [LEN_W-1:0]     wl_ff, wl_in, wr_ff, wr_in, wk_ff, wk_in;
   logic [LEN_W-1:0]     less_ff, less_in, rl_ff, rl_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                 kth_ff, kth_in;
   logic [16:0]          wv_ff, wv_in;
   logic [LEN_W-1:0]     t1_ff, t1_in, t2_ff, t2_in;
   logic [LEN_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [15:0]          ans_ff, ans_in;
   logic                 fnd_ff, fnd_in, bd_ff, bd_in;
   // build registers
   logic [LEN_W-1:0]     i_ff, i_in, p_ff, p_in, q_ff, q_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [LEN_W-1:0]     pfx_ff, pfx_in;

   // memories
   logic                 a_we, b_we, t_we, bits_we, pfx_we;
   logic [POS_W-1:0]     a_wa, a_ra, b_wa, b_ra, t_wa, t_ra;
   logic [VALUE_BITS-1:0] a_wd, a_rd, b_wd, b_rd, t_wd, t_rd;
   logic [ROW_W-1:0]     row_wa, row_ra;
   logic [WORD_BITS-1:0] bits_wd, bits_rd;
   logic [LEN_W-1:0]     pfx_wd, pfx_rd;
   logic [LEN_W-1:0]     rank_q;
   logic                 bit_q;
   logic [WORD_SH-1:0]   rank_off;
   rank_row_type         rrow;

   wmrq_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LENGTH)) u_buf_a (
      .clock, .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd), .rd_addr(a_ra), .rd_data(a_rd));
   wmrq_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LENGTH)) u_buf_b (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd));
   wmrq_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LENGTH)) u_buf_t (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   wmrq_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_bits (
      .clock, .wr_en(bits_we), .wr_addr(row_wa), .wr_data(bits_wd), .rd_addr(row_ra),
      .rd_data(bits_rd));
   wmrq_ram #(.WIDTH(LEN_W), .DEPTH(ROWS)) u_pfx (
      .clock, .wr_en(pfx_we), .wr_addr(row_wa), .wr_data(pfx_wd), .rd_addr(row_ra),
      .rd_data(pfx_rd));

   assign rrow = '{word: bits_rd, prefix: pfx_rd};

   wmrq_rank_unit u_rank (.clock, .row(rrow), .offset(rank_off), .rank_ff(rank_q),
                          .bit_ff(bit_q));

   logic [LEN_W-1:0]      zc_cur, cnt_rr, cnt_rl, rlen, span;
   logic [VALUE_BITS-1:0] cur_bit_v;
   logic                  vbit, range_ok;
   logic [3:0]            req_mode;
   logic [VALUE_BITS-1:0] bval;
   logic [LEN_W-1:0]      mid;

   always_comb begin
      zc_cur   = zc_ff[lvl_ff];
      cur_bit_v = VALUE_BITS'(1) << (LVL_W'(VALUE_BITS - 1) - lvl_ff);
      vbit     = |(wv_ff[VALUE_BITS-1:0] & cur_bit_v);
      cnt_rr   = rank_q;
      cnt_rl   = rl_ff;
      rlen     = rq_ff - lq_ff;
      span     = wr_ff - wl_ff;
      range_ok = (lq_ff <= rq_ff) && (rq_ff <= built_ff);
      req_mode = req_tdata[3:0];
      bval     = b_rd & cur_bit_v;
      mid      = LEN_W'((lo_ff + hi_ff) >> 1);
   end

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; mode_in = mode_ff;
      val_in = val_ff; uv_in = uv_ff; lq_in = lq_ff; rq_in = rq_ff; kq_in = kq_ff;
      stored_in = stored_ff; built_in = built_ff;
      lvl_in = lvl_ff; wl_in = wl_ff; wr_in = wr_ff; wk_in = wk_ff;
      less_in = less_ff; rl_in = rl_ff; acc_in = acc_ff; kth_in = kth_ff; wv_in = wv_ff;
      t1_in = t1_ff; t2_in = t2_ff; lo_in = lo_ff; hi_in = hi_ff;
      ans_in = ans_ff; fnd_in = fnd_ff; bd_in = bd_ff;
      i_in = i_ff; p_in = p_ff; q_in = q_ff; word_in = word_ff; pfx_in = pfx_ff;
      a_we = 1'b0; a_wa = stored_ff[POS_W-1:0]; a_wd = req_tdata[19:4];
      a_ra = i_ff[POS_W-1:0];
      b_we = 1'b0; b_wa = p_ff[POS_W-1:0]; b_wd = b_rd; b_ra = i_ff[POS_W-1:0];
      t_we = 1'b0; t_wa = q_ff[POS_W-1:0]; t_wd = b_rd; t_ra = i_ff[POS_W-1:0];
      bits_we = 1'b0; pfx_we = 1'b0;
      row_wa = {lvl_ff, i_ff[WORD_SH +: WORD_IDX_W]};
      row_ra = row_addr(lvl_ff, wl_ff);
      bits_wd = word_ff; pfx_wd = pfx_ff;
      rank_off = wl_ff[WORD_SH-1:0];
      zc_we = 1'b0; zc_wd = p_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = mode_type'(req_mode);
               val_in = req_tdata[19:4];
               uv_in  = req_tdata[36:20];
               lq_in  = req_tdata[47:37];
               rq_in  = req_tdata[58:48];
               kq_in  = req_tdata[69:59];
               if (req_mode == MODE_LOAD) begin
                  if (stored_ff < LEN_W'(MAX_LENGTH)) begin
                     a_we = 1'b1;
                     stored_in = stored_ff + 1'b1;
                  end
               end else if (req_mode == MODE_BUILD) begin
                  i_in = '0;
                  state_in = ST_BCOPY_RD;
               end else if (req_mode < 4'd12) begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         // ---------------- build ----------------
         ST_BCOPY_RD: begin
            if (i_ff == stored_ff) begin
               lvl_in = '0;
               state_in = ST_BLVL;
            end else begin
               state_in = ST_BCOPY_WR;
            end
         end
         ST_BCOPY_WR: begin
            b_we = 1'b1; b_wa = i_ff[POS_W-1:0]; b_wd = a_rd;
            i_in = i_ff + 1'b1;
            state_in = ST_BCOPY_RD;
         end
         ST_BLVL: begin
            i_in = '0; p_in = '0; q_in = '0; word_in = '0;
            state_in = ST_BSCAN_RD;
         end
         ST_BSCAN_RD: begin
            if (i_ff == stored_ff) begin
               state_in = ST_BFLUSH;
            end else begin
               state_in = ST_BSCAN_WR;
            end
         end
         ST_BSCAN_WR: begin
            if (|bval) begin
               t_we = 1'b1;
               q_in = q_ff + 1'b1;
               word_in = word_ff | (WORD_BITS'(1) << i_ff[WORD_SH-1:0]);
            end else begin
               b_we = 1'b1;
               p_in = p_ff + 1'b1;
            end
            if (&i_ff[WORD_SH-1:0]) begin
               bits_we = 1'b1;
               bits_wd = (|bval) ? (word_ff | (WORD_BITS'(1) << i_ff[WORD_SH-1:0]))
                                 : word_ff;
               word_in = '0;
            end
            i_in = i_ff + 1'b1;
            state_in = ST_BSCAN_RD;
         end
         ST_BFLUSH: begin
            // write the partial word and clear the rest of the row
            bits_we = 1'b1;
            zc_we = 1'b1;
            word_in = '0;
            if (i_ff[WORD_SH +: WORD_IDX_W] == WORD_IDX_W'(WORDS - 1)) begin
               i_in = '0;
               state_in = ST_BONES_RD;
            end else begin
               i_in = LEN_W'({i_ff[WORD_SH +: WORD_IDX_W] + 1'b1, WORD_SH'(0)});
            end
         end
         ST_BONES_RD: begin
            t_ra = i_ff[POS_W-1:0];
            if (i_ff == q_ff) begin
               i_in = '0; pfx_in = '0;
               state_in = ST_BPFX_RD;
            end else begin
               state_in = ST_BONES_WR;
            end
         end
         ST_BONES_WR: begin
            b_we = 1'b1; b_wa = POS_W'(p_ff + i_ff); b_wd = t_rd;
            i_in = i_ff + 1'b1;
            state_in = ST_BONES_RD;
         end
         ST_BPFX_RD: begin
            row_ra = {lvl_ff, i_ff[WORD_SH +: WORD_IDX_W]};
            state_in = ST_BPFX_WR;
         end
         ST_BPFX_WR: begin
            pfx_we = 1'b1;
            pfx_in = pfx_ff + LEN_W'(popcount32(bits_rd));
            if (i_ff[WORD_SH +: WORD_IDX_W] == WORD_IDX_W'(WORDS - 1)) begin
               if (lvl_ff == LVL_W'(VALUE_BITS - 1)) begin
                  built_in = stored_ff;
                  ans_in = 16'(stored_ff); fnd_in = 1'b1; bd_in = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  lvl_in = lvl_ff + 1'b1;
                  state_in = ST_BLVL;
               end
            end else begin
               i_in = LEN_W'({i_ff[WORD_SH +: WORD_IDX_W] + 1'b1, WORD_SH'(0)});
               state_in = ST_BPFX_RD;
            end
         end
         // ---------------- query dispatch ----------------
         ST_DISPATCH: begin
            ans_in = '0; fnd_in = 1'b0; bd_in = 1'b0;
            lvl_in = '0; less_in = '0; acc_in = '0;
            wv_in = {1'b0, val_ff};
            state_in = ST_RESP;
            unique case (mode_ff)
               MODE_ACCESS: if (kq_ff < built_ff) begin
                  phase_in = PH_ACCESS; wl_in = kq_ff; wr_in = kq_ff; kth_in = 1'b0;
                  state_in = ST_W_ADDR_L;
               end
               MODE_RANK: if (kq_ff <= built_ff) begin
                  phase_in = PH_RANK; wl_in = '0; wr_in = kq_ff; kth_in = 1'b0;
                  state_in = ST_W_ADDR_L;
               end
               MODE_SELECT: if (lq_ff <= built_ff) begin
                  phase_in = PH_SEL_TOT; wl_in = '0; wr_in = built_ff; kth_in = 1'b0;
                  state_in = ST_W_ADDR_L;
               end
               MODE_KLARGE, MODE_KSMALL: if (range_ok && kq_ff < rlen) begin
                  phase_in = PH_KTH; wl_in = lq_ff; wr_in = rq_ff; kth_in = 1'b1;
                  wk_in = (mode_ff == MODE_KLARGE) ? kq_ff : rlen - kq_ff - 1'b1;
                  state_in = ST_W_ADDR_L;
               end
               MODE_RCOUNT: if (range_ok) begin
                  fnd_in = 1'b1;
                  if ({1'b0, val_ff} < uv_ff) begin
                     phase_in = PH_RC_HI; wl_in = lq_ff; wr_in = rq_ff; kth_in = 1'b0;
                     wv_in = uv_ff;
                     state_in = ST_W_ADDR_L;
                  end
               end
               MODE_LESS, MODE_LESSEQ: if (range_ok) begin
                  phase_in = PH_CNT; wl_in = lq_ff; wr_in = rq_ff; kth_in = 1'b0;
                  state_in = ST_W_ADDR_L;
               end
               MODE_SUCC, MODE_PRED: if (range_ok) begin
                  phase_in = PH_SP_CNT; wl_in = lq_ff; wr_in = rq_ff; kth_in = 1'b0;
                  state_in = ST_W_ADDR_L;
               end
               default: state_in = ST_RESP;
            endcase
            if (mode_ff == MODE_RCOUNT && !range_ok) begin
               state_in = ST_RESP;
            end
         end
         // ---------------- level walk on the shared rank unit ----------------
         ST_W_ADDR_L: begin
            if (wv_ff[16] && !kth_ff && phase_ff != PH_ACCESS) begin
               less_in = span;
               wl_in = '0; wr_in = '0;
               state_in = ST_Q_NEXT;
            end else begin
               row_ra = row_addr(lvl_ff, wl_ff);
               state_in = ST_W_ADDR_R;
            end
         end
         ST_W_ADDR_R: begin
            rank_off = wl_ff[WORD_SH-1:0];
            row_ra = row_addr(lvl_ff, wr_ff);
            state_in = ST_W_RANK_L;
         end
         ST_W_RANK_L: begin
            rl_in = rank_q;
            rank_off = wr_ff[WORD_SH-1:0];
            acc_in = (phase_ff == PH_ACCESS) ? {acc_ff[VALUE_BITS-2:0], bit_q} : acc_ff;
            state_in = ST_W_STEP;
         end
         ST_W_STEP: begin
            if (phase_ff == PH_ACCESS) begin
               wl_in = acc_ff[0] ? cnt_rl + zc_cur : wl_ff - cnt_rl;
               wr_in = wl_in;
            end else if (kth_ff) begin
               if (cnt_rr - cnt_rl > wk_ff) begin
                  wl_in = cnt_rl + zc_cur; wr_in = cnt_rr + zc_cur;
                  acc_in = acc_ff | cur_bit_v;
               end else begin
                  wk_in = wk_ff - (cnt_rr - cnt_rl);
                  wl_in = wl_ff - cnt_rl; wr_in = wr_ff - cnt_rr;
               end
            end else if (vbit) begin
               less_in = less_ff + span - (cnt_rr - cnt_rl);
               wl_in = cnt_rl + zc_cur; wr_in = cnt_rr + zc_cur;
            end else begin
               wl_in = wl_ff - cnt_rl; wr_in = wr_ff - cnt_rr;
            end
            if (lvl_ff == LVL_W'(VALUE_BITS - 1)) begin
               state_in = ST_Q_NEXT;
            end else begin
               lvl_in = lvl_ff + 1'b1;
               state_in = ST_W_ADDR_L;
            end
         end
         ST_Q_NEXT: begin
            // less_ff: lower count, span: equal count, acc_ff: k-th value
            lvl_in = '0; less_in = '0; acc_in = '0;
            state_in = ST_RESP;
            unique case (phase_ff)
               PH_ACCESS: begin ans_in = acc_ff; fnd_in = 1'b1; end
               PH_RANK:   begin ans_in = 16'(span); fnd_in = 1'b1; end
               PH_KTH:    begin ans_in = acc_ff; fnd_in = 1'b1; end
               PH_CNT: begin
                  ans_in = 16'((mode_ff == MODE_LESS) ? less_ff : less_ff + span);
                  fnd_in = 1'b1;
               end
               PH_RC_HI: begin
                  t1_in = less_ff;
                  phase_in = PH_RC_LO; wl_in = lq_ff; wr_in = rq_ff;
                  state_in = ST_W_ADDR_L;
                  wv_in = {1'b0, val_ff};
               end
               PH_RC_LO: begin ans_in = 16'(t1_ff - less_ff); fnd_in = 1'b1; end
               PH_SP_CNT: begin
                  phase_in = PH_SP_KTH; wl_in = lq_ff; wr_in = rq_ff; kth_in = 1'b1;
                  if (mode_ff == MODE_SUCC) begin
                     wk_in = rlen - (less_ff + span) - 1'b1;
                     if (less_ff + span < rlen) state_in = ST_W_ADDR_L;
                  end else begin
                     wk_in = rlen - less_ff;
                     if (less_ff != '0) state_in = ST_W_ADDR_L;
                  end
               end
               PH_SP_KTH: begin ans_in = acc_ff; fnd_in = 1'b1; end
               PH_SEL_TOT: begin
                  t1_in = span;
                  phase_in = PH_SEL_L; wl_in = '0; wr_in = lq_ff;
                  state_in = ST_W_ADDR_L;
               end
               PH_SEL_L: begin
                  t2_in = span + kq_ff;
                  if (({1'b0, span} + {1'b0, kq_ff}) < {1'b0, t1_ff}) begin
                     lo_in = lq_ff; hi_in = built_ff - 1'b1;
                     if (lq_ff < built_ff - 1'b1) begin
                        phase_in = PH_SEL_MID; wl_in = '0;
                        wr_in = LEN_W'((lq_ff + built_ff - 1'b1) >> 1) + 1'b1;
                        state_in = ST_W_ADDR_L;
                     end else begin
                        ans_in = 16'(lq_ff); fnd_in = 1'b1;
                     end
                  end
               end
               PH_SEL_MID: begin
                  if (span > t2_ff) begin
                     hi_in = mid;
                  end else begin
                     lo_in = mid + 1'b1;
                  end
                  if (lo_in < hi_in) begin
                     wl_in = '0;
                     wr_in = LEN_W'((lo_in + hi_in) >> 1) + 1'b1;
                     state_in = ST_W_ADDR_L;
                  end else begin
                     ans_in = 16'(lo_in); fnd_in = 1'b1;
                  end
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stored_ff <= '0;
         built_ff <= '0;
         for (int j = 0; j < VALUE_BITS; j++) zc_ff[j] <= '0;
      end else begin
         state_ff <= state_in;
         stored_ff <= stored_in;
         built_ff <= built_in;
         if (zc_we) zc_ff[lvl_ff] <= zc_wd;
      end
      phase_ff <= phase_in; mode_ff <= mode_in;
      val_ff <= val_in; uv_ff <= uv_in; lq_ff <= lq_in; rq_ff <= rq_in; kq_ff <= kq_in;
      lvl_ff <= lvl_in; wl_ff <= wl_in; wr_ff <= wr_in; wk_ff <= wk_in;
      less_ff <= less_in; rl_ff <= rl_in; acc_ff <= acc_in; kth_ff <= kth_in;
      wv_ff <= wv_in; t1_ff <= t1_in; t2_ff <= t2_in; lo_ff <= lo_in; hi_ff <= hi_in;
      ans_ff <= ans_in; fnd_ff <= fnd_in; bd_ff <= bd_in;
      i_ff <= i_in; p_ff <= p_in; q_ff <= q_in; word_ff <= word_in; pfx_ff <= pfx_in;
   end

   // prefix row is written in ST_BPFX_WR with the running total before this word
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
      rsp_tdata  = {6'd0, bd_ff, fnd_ff, ans_ff};
   end

endmodule

### hw/rtl/wmrq_checker.sv
// ----------------------------------------------------------------------------
// wmrq_checker
// Port-level checks of the wavelet matrix range query block.
// ----------------------------------------------------------------------------
module wmrq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> rsp_tdata[15:0] == 16'd0 && !rsp_tdata[17])
      else $error("missing answer not zero");

   a_bd_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[16])
      else $error("build acknowledge without found");

endmodule

bind wavelet_matrix_range_query wmrq_checker u_wmrq_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);

### sim/tb_wavelet_matrix_range_query.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wavelet_matrix_range_query
// Loads value sequences, builds, and runs every query kind against a direct
// scan of the built sequence; random stalls on both stream ports.
// ----------------------------------------------------------------------------
module tb_wavelet_matrix_range_query;
   import wmrq_pkg::*;

   typedef struct {
      logic [15:0] answer;
      logic        found;
      logic        build_done;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [3:0] mode, [19:4] value, [36:20] upper_value, [47:37] left,
   // [58:48] right, [69:59] ordinal, [71:70] zero
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [15:0] answer, [16] found, [17] build_done, [23:18] zero
   logic [23:0] rsp_tdata;

   logic [15:0] loaded_values [MAX_LENGTH];
   logic [15:0] built_values  [MAX_LENGTH];
   int          loaded_len;
   int          built_len;
   answer_type  pending_answers [$];
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_receiver;
   int          mismatches;

   wavelet_matrix_range_query DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #300ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic answer_type answer_query(mode_type mode, int v, int uv, int l, int r,
                                               int k);
      answer_type res;
      int         slice [$];
      int         n;
      int         cnt;
      int         below;
      int         atv;
      n = built_len;
      res = '{16'd0, 1'b0, 1'b0};
      if (l <= r && r <= n)
         for (int i = l; i < r; i++) slice.push_back(built_values[i]);
      slice.sort();
      below = 0;
      atv = 0;
      foreach (slice[i]) begin
         if (slice[i] < v) below++;
         if (slice[i] == v) atv++;
      end
      case (mode)
         MODE_ACCESS: if (k < n) begin
            res.answer = built_values[k];
            res.found = 1'b1;
         end
         MODE_RANK: if (k <= n) begin
            cnt = 0;
            for (int i = 0; i < k; i++) if (built_values[i] == v) cnt++;
            res.answer = cnt;
            res.found = 1'b1;
         end
         MODE_SELECT: if (l <= n) begin
            cnt = 0;
            for (int i = l; i < n; i++)
               if (built_values[i] == v) begin
                  if (cnt == k && !res.found) begin
                     res.answer = i;
                     res.found = 1'b1;
                  end
                  cnt++;
               end
         end
         MODE_KLARGE: if (l <= r && r <= n && k < r - l) begin
            res.answer = slice[slice.size() - 1 - k];
            res.found = 1'b1;
         end
         MODE_KSMALL: if (l <= r && r <= n && k < r - l) begin
            res.answer = slice[k];
            res.found = 1'b1;
         end
         MODE_RCOUNT: if (l <= r && r <= n) begin
            cnt = 0;
            foreach (slice[i]) if (slice[i] >= v && slice[i] < uv) cnt++;
            res.answer = cnt;
            res.found = 1'b1;
         end
         MODE_LESS: if (l <= r && r <= n) begin
            res.answer = below;
            res.found = 1'b1;
         end
         MODE_LESSEQ: if (l <= r && r <= n) begin
            res.answer = below + atv;
            res.found = 1'b1;
         end
         MODE_SUCC: if (l <= r && r <= n && below + atv < slice.size()) begin
            res.answer = slice[below + atv];
            res.found = 1'b1;
         end
         MODE_PRED: if (l <= r && r <= n && below > 0) begin
            res.answer = slice[below - 1];
            res.found = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic record_request(int mode, int v, int uv, int l, int r, int k);
      answer_type res;
      if (mode == MODE_LOAD) begin
         if (loaded_len < MAX_LENGTH) begin
            loaded_values[loaded_len] = v;
            loaded_len++;
         end
      end else if (mode == MODE_BUILD) begin
         for (int i = 0; i < loaded_len; i++) built_values[i] = loaded_values[i];
         built_len = loaded_len;
         res = '{16'(built_len), 1'b1, 1'b1};
         pending_answers.push_back(res);
      end else if (mode <= MODE_PRED) begin
         pending_answers.push_back(answer_query(mode_type'(mode), v, uv, l, r, k));
      end
   endtask

   task automatic send_request(int mode, int v, int uv = 0, int l = 0, int r = 0,
                               int k = 0);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, 11'(k), 11'(r), 11'(l), 17'(uv), 16'(v), 4'(mode)};
      do @(posedge clock); while (!req_tready);
      record_request(mode, v, uv, l, r, k);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[17]};
         if (pending_answers.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response actual %h", $time, rsp_tdata);
         end else begin
            want = pending_answers.pop_front();
            if (got.answer != want.answer || got.found != want.found ||
                got.build_done != want.build_done) begin
               mismatches++;
               $display("%0t: expected answer %0d found %b build_done %b, actual %0d %b %b",
                        $time, want.answer, want.found, want.build_done,
                        got.answer, got.found, got.build_done);
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int pick_value();
      case ($urandom_range(5))
         0: return $urandom_range(65535);
         1: return $urandom_range(1) ? 65535 : 0;
         2: return built_len > 0 ? built_values[$urandom_range(built_len - 1)] : 0;
         default: return $urandom_range(15) << ($urandom_range(1) ? 12 : 0);
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] seed_vals [7] = '{16'd0, 16'hFFFF, 16'd7, 16'd7, 16'h8000, 16'd7,
                                     16'h1234};
      send_request(MODE_BUILD, 0);
      send_request(MODE_RANK, 5, 0, 0, 0, 0);
      send_request(MODE_ACCESS, 0, 0, 0, 0, 0);
      send_request(MODE_KLARGE, 0, 0, 0, 0, 0);
      send_request(MODE_SELECT, 0, 0, 0, 0, 0);
      foreach (seed_vals[i])
         send_request(MODE_LOAD, seed_vals[i]);
      send_request(MODE_BUILD, 0);
      send_request(MODE_ACCESS, 0, 0, 0, 0, 6);
      send_request(MODE_ACCESS, 0, 0, 0, 0, 7);
      send_request(MODE_RANK, 7, 0, 0, 0, 7);
      send_request(MODE_SELECT, 7, 0, 3, 0, 1);
      send_request(MODE_SELECT, 7, 0, 0, 0, 3);
      send_request(MODE_KLARGE, 0, 0, 0, 7, 0);
      send_request(MODE_KSMALL, 0, 0, 2, 7, 4);
      send_request(MODE_KSMALL, 0, 0, 2, 7, 5);
      send_request(MODE_RCOUNT, 7, 65536, 0, 7);
      send_request(MODE_RCOUNT, 9, 7, 0, 7);
      send_request(MODE_LESS, 65535, 0, 0, 7);
      send_request(MODE_LESSEQ, 7, 0, 5, 3);
      send_request(MODE_SUCC, 65535, 0, 0, 7);
      send_request(MODE_PRED, 0, 0, 0, 7);
      send_request(MODE_PRED, 7, 0, 0, 8);
      send_request(12, 0);
      send_request(15, 65535, 131071, 2047, 2047, 2047);
      wait_drained();
   endtask

   task automatic test_random(int loads, int queries);
      int l;
      int r;
      for (int i = 0; i < loads; i++) send_request(MODE_LOAD, pick_value());
      send_request(MODE_BUILD, 0);
      for (int i = 0; i < queries; i++) begin
         l = $urandom_range(built_len);
         r = $urandom_range(built_len);
         if (l > r && $urandom_range(3) != 0) {l, r} = {r, l};
         if ($urandom_range(9) == 0) begin
            l = $urandom_range(2047);
            r = $urandom_range(2047);
         end
         send_request($urandom_range(15) == 0 ? $urandom_range(15) : $urandom_range(2, 11),
                      pick_value(),
                      $urandom_range(3) == 0 ? $urandom_range(131071) : pick_value() + 1,
                      l, r,
                      $urandom_range(3) == 0 ? $urandom_range(2047)
                                             : $urandom_range(r > l ? r - l : 3));
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_receiver = 1'b1;
      for (int i = 0; i < 20; i++)
         send_request(MODE_LESSEQ, pick_value(), 0, 0, built_len);
      wait_drained();
   endtask

   task automatic test_full_store();
      while (loaded_len < MAX_LENGTH) send_request(MODE_LOAD, $urandom_range(65535));
      send_request(MODE_LOAD, 16'h5555);
      send_request(MODE_LOAD, 16'hAAAA);
      test_random(0, 80);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      hold_receiver = 1'b0;
      mismatches = 0;
      loaded_len = 0;
      built_len = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 27;
      recv_idle_pct = 82;
      test_directed();
      test_random(40, 250);
      test_backpressure();
      send_idle_pct = 82;
      recv_idle_pct = 27;
      test_random(60, 250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(100, 150);
      test_random(30, 100);
      test_full_store();
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/wmrq_pkg.sv
hw/rtl/wmrq_ram.sv
hw/rtl/wmrq_rank_unit.sv
hw/rtl/wavelet_matrix_range_query.sv
hw/rtl/wmrq_checker.sv
sim/tb_wavelet_matrix_range_query.sv
